// ----- rtl/assert_macros.svh -----
// assertion helper macros for the executor checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define CHK_IMPLY(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("executor check failed");

// next-cycle implication, ignored while reset is high
`define CHK_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("executor check failed");

`endif

// ----- rtl/msie_pkg.sv -----
// shared types, opcodes and constants of the mips subset executor
`default_nettype none

package msie_pkg;

  localparam int MEM_WORDS_DEF = 4096;
  localparam int QDEPTH = 2;

  localparam logic [5:0] OP_SPECIAL = 6'b000000;
  localparam logic [5:0] OP_J       = 6'b000010;
  localparam logic [5:0] OP_JAL     = 6'b000011;
  localparam logic [5:0] OP_LW      = 6'b100011;
  localparam logic [5:0] OP_SW      = 6'b101011;

  localparam logic [5:0] FN_ADD = 6'b100000;
  localparam logic [5:0] FN_SUB = 6'b100010;
  localparam logic [5:0] FN_SLL = 6'b000000;
  localparam logic [5:0] FN_SRL = 6'b000010;
  localparam logic [5:0] FN_JR  = 6'b001000;

  localparam logic [3:0] CLS_ADD = 4'd0;
  localparam logic [3:0] CLS_SUB = 4'd1;
  localparam logic [3:0] CLS_SLL = 4'd2;
  localparam logic [3:0] CLS_SRL = 4'd3;
  localparam logic [3:0] CLS_JR  = 4'd4;
  localparam logic [3:0] CLS_LW  = 4'd5;
  localparam logic [3:0] CLS_SW  = 4'd6;
  localparam logic [3:0] CLS_J   = 4'd7;
  localparam logic [3:0] CLS_JAL = 4'd8;
  localparam logic [3:0] CLS_BAD = 4'd9;

  typedef struct packed {
    logic [3:0]  cls;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  dest;
    logic [4:0]  shamt;
    logic [15:0] imm;
    logic [11:0] target;
  } dec_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [11:0] mem_addr;
    logic [31:0] mem_data;
    logic        status;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/msie_front.sv -----
// front stage: accepts instruction words and decodes them into classes
`default_nettype none

module msie_front import msie_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] instruction_word,
  input  wire logic        clearing,
  input  wire logic        q_full,
  output logic             f_valid,
  output dec_t             f_item
);

  logic       valid;
  dec_t       item;
  dec_t       dec;
  logic       accept;
  logic       move;
  logic [5:0] op;
  logic [5:0] fn;

  assign op = instruction_word[31:26];
  assign fn = instruction_word[5:0];

  always_comb begin
    dec        = '0;
    dec.rs     = instruction_word[25:21];
    dec.rt     = instruction_word[20:16];
    dec.dest   = instruction_word[15:11];
    dec.shamt  = instruction_word[10:6];
    dec.imm    = instruction_word[15:0];
    dec.target = instruction_word[11:0];
    unique case (op)
      OP_SPECIAL: begin
        unique case (fn)
          FN_ADD:  dec.cls = CLS_ADD;
          FN_SUB:  dec.cls = CLS_SUB;
          FN_SLL:  dec.cls = CLS_SLL;
          FN_SRL:  dec.cls = CLS_SRL;
          FN_JR:   dec.cls = CLS_JR;
          default: dec.cls = CLS_BAD;
        endcase
      end
      OP_LW: begin
        dec.cls  = CLS_LW;
        dec.dest = instruction_word[20:16];
      end
      OP_SW:  dec.cls = CLS_SW;
      OP_J:   dec.cls = CLS_J;
      OP_JAL: begin
        dec.cls  = CLS_JAL;
        dec.dest = 5'd31;
      end
      default: dec.cls = CLS_BAD;
    endcase
  end

  assign full    = clearing || (valid && q_full);
  assign accept  = push && !full;
  assign move    = valid && !q_full;
  assign f_valid = valid;
  assign f_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (move) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= dec;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/msie_queue.sv -----
// small queue of decoded instructions between the front and back stages
`default_nettype none

module msie_queue import msie_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire dec_t in_item,
  output logic      full,
  output logic      out_valid,
  output dec_t      out_item,
  input  wire logic out_pop
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  dec_t          slots [QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          push_ok;
  logic          pop_ok;

  assign full      = (count == CW'(QDEPTH));
  assign out_valid = (count != '0);
  assign out_item  = slots[rptr];
  assign push_ok   = in_valid && !full;
  assign pop_ok    = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop_ok) begin
        rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/msie_addr_mod.sv -----
// load/store word address: base plus offset reduced modulo the memory size
`default_nettype none

module msie_addr_mod import msie_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [31:0]                  sum,
  output logic [$clog2(MEM_WORDS)-1:0]      addr,
  output logic                              ok
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam bit POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

  generate
    if (POW2) begin : g_mask
      logic [AW-1:0] addr_q;
      logic          ok_q;

      always_ff @(posedge clk) begin
        if (rst) begin
          ok_q <= 1'b0;
        end else if (start) begin
          ok_q <= 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          addr_q <= sum[AW-1:0];
        end
      end

      assign addr = addr_q;
      assign ok   = ok_q;
    end else begin : g_rem
      // reciprocal multiply gives the quotient or one less, one correction step
      // fixes the remainder; x, prod, r_est and rem are registered in turn after start
      localparam logic [32:0] RECIP = 33'((64'd1 << (32 + AW)) / 64'(MEM_WORDS));
      localparam logic [AW:0] MODV  = (AW + 1)'(MEM_WORDS);

      logic [31:0]     x;
      logic [64:0]     prod;
      logic [AW:0]     qlow;
      logic [2*AW+1:0] qm;
      logic [AW:0]     r_est;
      logic [AW-1:0]   rem;
      logic [2:0]      stage;
      logic            ok_q;

      assign qlow = prod[32+AW +: AW+1];
      assign qm   = {{(AW+1){1'b0}}, qlow} * {{(AW+1){1'b0}}, MODV};

      always_ff @(posedge clk) begin
        if (rst) begin
          stage <= '0;
          ok_q  <= 1'b0;
        end else begin
          stage <= {stage[1:0], start};
          if (start) begin
            ok_q <= 1'b0;
          end else if (stage[2]) begin
            ok_q <= 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          x <= sum;
        end
        if (stage[0]) begin
          prod <= {33'd0, x} * {32'd0, RECIP};
        end
        if (stage[1]) begin
          r_est <= x[AW:0] - qm[AW:0];
        end
        if (stage[2]) begin
          rem <= (r_est >= MODV) ? AW'(r_est - MODV) : r_est[AW-1:0];
        end
      end

      assign addr = rem;
      assign ok   = ok_q;
    end
  endgenerate

endmodule

`default_nettype wire

// ----- rtl/msie_back.sv -----
// back stage: register file, data memory, pc, execution and result register
`default_nettype none

module msie_back import msie_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire dec_t q_item,
  output logic      q_pop,
  output logic      clearing,
  input  wire logic pop,
  output logic      empty,
  output res_t      res
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_ADDR  = 3'd3;
  localparam logic [2:0] ST_MEM   = 3'd4;

  logic [2:0]    state;
  logic [2:0]    state_next;
  dec_t          ir;
  logic [31:0]   rf [32];
  logic [31:0]   rf_valid;
  logic [31:0]   rs_data;
  logic [31:0]   rt_data;
  logic          rs_ok;
  logic          rt_ok;
  logic [31:0]   dmem [MEM_WORDS];
  logic [31:0]   rdata;
  logic [AW-1:0] clr_cnt;
  logic [11:0]   pc;
  logic [11:0]   pc_inc;
  logic          out_valid;
  res_t          res_n;
  logic [31:0]   a;
  logic [31:0]   b;
  logic [31:0]   sum;
  logic [AW-1:0] maddr;
  logic [31:0]   maddr_ext;
  logic          addr_ok;
  logic          slot_free;
  logic          done;
  logic          mod_start;
  logic          mem_rd;
  logic          mem_wr;
  logic          wr;
  logic [31:0]   wval;

  assign clearing  = (state == ST_CLEAR);
  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign a         = rs_ok ? rs_data : 32'd0;
  assign b         = rt_ok ? rt_data : 32'd0;
  assign sum       = a + {{16{ir.imm[15]}}, ir.imm};
  assign maddr_ext = 32'(maddr);
  assign pc_inc    = pc + 12'd1;

  msie_addr_mod #(
    .MEM_WORDS(MEM_WORDS)
  ) u_addr (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .sum  (sum),
    .addr (maddr),
    .ok   (addr_ok)
  );

  // sequencer
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    done       = 1'b0;
    mod_start  = 1'b0;
    mem_rd     = 1'b0;
    mem_wr     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (ir.cls == CLS_LW || ir.cls == CLS_SW) begin
          mod_start  = 1'b1;
          state_next = ST_ADDR;
        end else if (slot_free) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_ADDR: begin
        if (addr_ok) begin
          if (ir.cls == CLS_LW) begin
            mem_rd     = 1'b1;
            state_next = ST_MEM;
          end else if (slot_free) begin
            mem_wr     = 1'b1;
            done       = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_MEM: begin
        if (slot_free) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result of the instruction in ir
  always_comb begin
    res_n         = '0;
    res_n.next_pc = pc_inc;
    wr            = 1'b0;
    wval          = 32'd0;
    unique case (ir.cls)
      CLS_ADD: begin
        wr   = 1'b1;
        wval = a + b;
      end
      CLS_SUB: begin
        wr   = 1'b1;
        wval = a - b;
      end
      CLS_SLL: begin
        wr   = 1'b1;
        wval = b << ir.shamt;
      end
      CLS_SRL: begin
        wr   = 1'b1;
        wval = b >> ir.shamt;
      end
      CLS_JR:  res_n.next_pc = a[11:0];
      CLS_LW: begin
        wr             = 1'b1;
        wval           = rdata;
        res_n.mem_addr = maddr_ext[11:0];
        res_n.mem_data = rdata;
      end
      CLS_SW: begin
        res_n.mem_write = 1'b1;
        res_n.mem_addr  = maddr_ext[11:0];
        res_n.mem_data  = b;
      end
      CLS_J:   res_n.next_pc = ir.target;
      CLS_JAL: begin
        wr            = 1'b1;
        wval          = {20'd0, pc_inc};
        res_n.next_pc = ir.target;
      end
      default: begin
        res_n.next_pc = pc;
        res_n.status  = 1'b1;
      end
    endcase
    // register zero drops the write
    if (wr && ir.dest != 5'd0) begin
      res_n.reg_write = 1'b1;
      res_n.reg_index = ir.dest;
      res_n.reg_value = wval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      pc        <= 12'd0;
      out_valid <= 1'b0;
      rf_valid  <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (done) begin
        out_valid <= 1'b1;
        pc        <= res_n.next_pc;
        if (res_n.reg_write) begin
          rf_valid[ir.dest] <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ir      <= q_item;
      rs_data <= rf[q_item.rs];
      rt_data <= rf[q_item.rt];
      rs_ok   <= rf_valid[q_item.rs];
      rt_ok   <= rf_valid[q_item.rt];
    end
    if (done) begin
      res <= res_n;
      if (res_n.reg_write) begin
        rf[ir.dest] <= res_n.reg_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      dmem[clr_cnt] <= 32'd0;
    end else if (mem_wr) begin
      dmem[maddr] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rdata <= dmem[maddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mips_subset_instruction_executor.sv -----
// Alu and jump instructions pass the register read and execute steps of the back
// sequencer; sw adds the address step, lw adds the address and memory read steps.
// It runs one instruction at a time; the front register and queue buffer new words.
// A memory size that is not a power of two adds a registered address reduction.
// After reset the data memory is cleared one word a cycle, with full held high
// until clearing ends; registers and pc read zero right after reset.
`default_nettype none

`include "assert_macros.svh"

module mips_subset_instruction_executor import msie_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] instruction_word,
  output logic             empty,
  input  wire logic        pop,
  output logic [11:0]      next_pc,
  output logic             reg_write,
  output logic [4:0]       reg_index,
  output logic [31:0]      reg_value,
  output logic             mem_write,
  output logic [11:0]      mem_addr,
  output logic [31:0]      mem_data,
  output logic             status
);

  // front register -> queue -> back sequencer -> result register
  logic clearing;
  logic f_valid;
  dec_t f_item;
  logic q_full;
  logic q_valid;
  dec_t q_item;
  logic q_pop;
  res_t res;

  // front: takes a transfer when not full, decodes into a class
  msie_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .instruction_word(instruction_word),
    .clearing        (clearing),
    .q_full          (q_full),
    .f_valid         (f_valid),
    .f_item          (f_item)
  );

  // decouples decode from execution so each side stalls on its own
  msie_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_item  (f_item),
    .full     (q_full),
    .out_valid(q_valid),
    .out_item (q_item),
    .out_pop  (q_pop)
  );

  // back: owns register file, data memory and pc; result register feeds
  // the output side, so the next instruction executes while a result waits
  msie_back #(
    .MEM_WORDS(MEM_WORDS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .clearing(clearing),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign next_pc   = res.next_pc;
  assign reg_write = res.reg_write;
  assign reg_index = res.reg_index;
  assign reg_value = res.reg_value;
  assign mem_write = res.mem_write;
  assign mem_addr  = res.mem_addr;
  assign mem_data  = res.mem_data;
  assign status    = res.status;

  // no input transfer while the memory is being cleared
  `CHK_IMPLY(a_clear_blocks_push, clk, rst, clearing, full)
  // an unknown instruction leaves no side effects
  `CHK_IMPLY(a_bad_no_effect, clk, rst, !empty && status, !reg_write && !mem_write && reg_value == 32'd0)
  // register zero is never reported as written
  `CHK_IMPLY(a_no_zero_write, clk, rst, !empty && reg_write, reg_index != 5'd0)
  // nothing can reach the output right after clearing ends
  `CHK_NEXT(a_clear_end_empty, clk, rst, $fell(clearing), empty)

endmodule

`default_nettype wire

// ----- sim/msie_exec_checker.sv -----
// checker for the mips subset executor: predicts each result and compares transfers
`default_nettype none

module msie_exec_checker import msie_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [31:0] instruction_word,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [11:0] next_pc,
  input  wire logic        reg_write,
  input  wire logic [4:0]  reg_index,
  input  wire logic [31:0] reg_value,
  input  wire logic        mem_write,
  input  wire logic [11:0] mem_addr,
  input  wire logic [31:0] mem_data,
  input  wire logic        status,
  output int               mismatches,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;

  logic [31:0] gpr [32];
  logic [31:0] dmem [MEM_WORDS];
  logic [11:0] pc;
  res_t        due_results [$];
  res_t        want;
  int          results_seen;

  task automatic report(input string what);
    if (mismatches < PRINT_CAP) $display("[%0t] %s", $realtime, what);
    mismatches++;
  endtask

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] exp_val);
    if (got !== exp_val)
      report($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                       results_seen, field, got, exp_val));
  endtask

  // architectural update for one instruction; r0 is never written so it reads zero
  function automatic res_t execute_instruction(input logic [31:0] w);
    res_t        r;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] eff;
    logic [11:0] seq_pc;
    logic        known;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;
    int unsigned slot;

    op = w[31:26];
    rs = w[25:21];
    rt = w[20:16];
    rd = w[15:11];
    sh = w[10:6];
    fn = w[5:0];
    a = gpr[rs];
    b = gpr[rt];
    seq_pc = pc + 12'd1;
    eff = a + {{16{w[15]}}, w[15:0]};
    slot = eff % MEM_WORDS;
    r = '0;
    r.next_pc = seq_pc;
    known = 1'b1;
    wr = 1'b0;
    widx = '0;
    wval = '0;

    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_ADD: begin wr = 1'b1; widx = rd; wval = a + b; end
          FN_SUB: begin wr = 1'b1; widx = rd; wval = a - b; end
          FN_SLL: begin wr = 1'b1; widx = rd; wval = b << sh; end
          FN_SRL: begin wr = 1'b1; widx = rd; wval = b >> sh; end
          FN_JR:  r.next_pc = a[11:0];
          default: known = 1'b0;
        endcase
      end
      OP_LW: begin
        r.mem_addr = slot[11:0];
        r.mem_data = dmem[slot];
        wr = 1'b1;
        widx = rt;
        wval = dmem[slot];
      end
      OP_SW: begin
        r.mem_addr = slot[11:0];
        r.mem_data = b;
        r.mem_write = 1'b1;
        dmem[slot] = b;
      end
      OP_J: r.next_pc = w[11:0];
      OP_JAL: begin
        wr = 1'b1;
        widx = 5'd31;
        wval = {20'd0, seq_pc};
        r.next_pc = w[11:0];
      end
      default: known = 1'b0;
    endcase

    if (!known) begin
      r = '0;
      r.next_pc = pc;
      r.status = 1'b1;
      return r;
    end
    if (wr && widx != 5'd0) begin
      gpr[widx] = wval;
      r.reg_write = 1'b1;
      r.reg_index = widx;
      r.reg_value = wval;
    end
    pc = r.next_pc;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc = '0;
      due_results.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (push && !full)
        due_results.insert(due_results.size(), execute_instruction(instruction_word));
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          report($sformatf("result %0d arrived with no instruction outstanding",
                           results_seen));
        end else begin
          want = due_results.pop_front();
          compare_field("next_pc",   next_pc,   want.next_pc);
          compare_field("reg_write", reg_write, want.reg_write);
          compare_field("reg_index", reg_index, want.reg_index);
          compare_field("reg_value", reg_value, want.reg_value);
          compare_field("mem_write", mem_write, want.mem_write);
          compare_field("mem_addr",  mem_addr,  want.mem_addr);
          compare_field("mem_data",  mem_data,  want.mem_data);
          compare_field("status",    status,    want.status);
        end
        results_seen++;
      end
    end
    pending = due_results.size();
  end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// top of the executor testbench: clock, reset, instruction stimulus, result pacing, verdict
`default_nettype none

module tb import msie_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // encodings the block must reject
  localparam logic [5:0] OP_ADDI_UNSUPPORTED = 6'b001000;
  localparam logic [5:0] FN_ADDU_UNSUPPORTED = 6'b100001;

  localparam int RANDOM_ITEMS     = 550;
  localparam int LONG_HOLD_AT     = 100;   // items sent before the receiver goes quiet
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_PAUSE_AT   = 350;   // items sent before the sender waits for all results
  localparam int DRAIN_CYCLES     = 40;
  // budget for the memory clear after reset and for every item at lw pace, with
  // sender gaps and receiver stalls; taken several times over
  localparam int CYCLE_LIMIT      = 200_000;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [31:0] instruction_word;
  logic        empty;
  logic        pop;
  logic [11:0] next_pc;
  logic        reg_write;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic        mem_write;
  logic [11:0] mem_addr;
  logic [31:0] mem_data;
  logic        status;
  int          mismatches;
  int          pending;

  int          sent_count;
  int          burst;
  int          pick;
  int          cycles;
  int          hold;
  int          pace_left;
  int          pace_mode;
  bit          drain_pause_done;
  bit          long_hold_done;
  logic [31:0] word;

  mips_subset_instruction_executor dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .instruction_word (instruction_word),
    .empty            (empty),
    .pop              (pop),
    .next_pc          (next_pc),
    .reg_write        (reg_write),
    .reg_index        (reg_index),
    .reg_value        (reg_value),
    .mem_write        (mem_write),
    .mem_addr         (mem_addr),
    .mem_data         (mem_data),
    .status           (status)
  );

  msie_exec_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .instruction_word (instruction_word),
    .empty            (empty),
    .pop              (pop),
    .next_pc          (next_pc),
    .reg_write        (reg_write),
    .reg_index        (reg_index),
    .reg_value        (reg_value),
    .mem_write        (mem_write),
    .mem_addr         (mem_addr),
    .mem_data         (mem_data),
    .status           (status),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // instruction field packing
  function automatic logic [31:0] r_type(input logic [4:0] rs, input logic [4:0] rt,
                                         input logic [4:0] rd, input logic [4:0] sh,
                                         input logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_type(input logic [5:0] op, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] j_type(input logic [5:0] op, input logic [25:0] target);
    return {op, target};
  endfunction

  // lw/sw mostly hit a small set of addresses at both ends of memory through r0,
  // so loads find earlier stores; the offset's top nibble still varies the sign
  function automatic logic [31:0] mem_access(input logic [5:0] op);
    logic [4:0]  base;
    logic [11:0] spot;
    logic [15:0] imm;
    base = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'd0;
    spot = $urandom_range(0, 1) ? 12'($urandom_range(0, 7))
                                : 12'(12'hFF8 + $urandom_range(0, 7));
    imm = ($urandom_range(0, 3) == 0) ? 16'($urandom) : {4'($urandom), spot};
    return i_type(op, base, 5'($urandom), imm);
  endfunction

  // one transfer: hold push and the word from a falling edge until a rising
  // edge sees full low, then return on the following falling edge
  task automatic send_word(input logic [31:0] w);
    push <= 1'b1;
    instruction_word <= w;
    do @(posedge clk); while (full);
    sent_count++;
    @(negedge clk);
  endtask

  // sender lowers push and waits for every predicted result to drain
  task automatic wait_drained();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // receiver: pops in changing moods, plus one long hold-off so the block
  // fills and pushes back on the sender
  initial begin
    pop = 1'b0;
    long_hold_done = 1'b0;
    pace_left = 0;
    pace_mode = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!long_hold_done && sent_count >= LONG_HOLD_AT) begin
        pop <= 1'b0;
        for (hold = 0; hold < LONG_HOLD_CYCLES; hold++) @(negedge clk);
        long_hold_done = 1'b1;
      end else begin
        if (pace_left == 0) begin
          pace_mode = $urandom_range(0, 2);
          pace_left = $urandom_range(8, 60);
        end
        pace_left--;
        case (pace_mode)
          0:       pop <= 1'b1;                          // free-flowing stretch
          1:       pop <= 1'($urandom_range(0, 1));
          default: pop <= ($urandom_range(0, 3) == 0);   // mostly stalled
        endcase
      end
    end
  end

  // sender and verdict
  initial begin
    rst = 1'b1;
    push = 1'b0;
    instruction_word = '0;
    sent_count = 0;
    drain_pause_done = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, register values noted as expected after each step
    send_word(j_type(OP_JAL, 26'h3FF_FFFF));                        // r31 = 1, pc = fff
    send_word(r_type(5'd0, 5'd31, 5'd1, 5'd7, FN_SUB));             // r1 = ffffffff, shamt ignored
    send_word(r_type(5'd1, 5'd1, 5'd2, 5'd0, FN_ADD));              // add wraps
    send_word(r_type(5'd9, 5'd1, 5'd3, 5'd31, FN_SLL));             // rs ignored, r3 = 80000000
    send_word(r_type(5'd0, 5'd3, 5'd4, 5'd31, FN_SRL));             // logical, r4 = 1
    send_word(r_type(5'd0, 5'd1, 5'd5, 5'd0, FN_SLL));              // zero shift
    send_word(r_type(5'd1, 5'd1, 5'd0, 5'd0, FN_ADD));              // write to r0 dropped
    send_word(i_type(OP_SW, 5'd0, 5'd1, 16'h7FFF));                 // top of memory
    send_word(i_type(OP_SW, 5'd4, 5'd3, 16'hFFFF));                 // negative offset, word 0
    send_word(i_type(OP_LW, 5'd0, 5'd6, 16'h7FFF));
    send_word(i_type(OP_LW, 5'd4, 5'd0, 16'hFFFF));                 // load into r0 still reports data
    send_word(i_type(OP_SW, 5'd1, 5'd2, 16'h8000));                 // 32-bit address wrap
    send_word(i_type(OP_LW, 5'd0, 5'd7, 16'h0123));                 // never stored, reads zero
    send_word(j_type(OP_J, 26'h2AB_CDEF));                          // only low 12 target bits
    send_word({OP_SPECIAL, 5'd1, 5'd31, 5'd31, 5'd31, FN_JR});      // ignored fields set, pc = fff
    send_word(j_type(OP_JAL, 26'h000_0000));                        // link wraps to 0
    send_word(r_type(5'd0, 5'd0, 5'd0, 5'd0, FN_JR));               // jr through r0
    send_word(32'hFFFF_FFFF);                                       // unknown opcode
    send_word(r_type(5'd1, 5'd1, 5'd8, 5'd0, FN_ADDU_UNSUPPORTED)); // unknown funct
    send_word(i_type(OP_ADDI_UNSUPPORTED, 5'd1, 5'd8, 16'h0001));
    send_word(r_type(5'd0, 5'd0, 5'd7, 5'd0, FN_SUB));              // writes zero to r7
    send_word(r_type(5'd0, 5'd1, 5'd8, 5'd0, FN_SRL));
    send_word(32'h0000_0000);                                       // sll r0: a nop
    send_word(r_type(5'd0, 5'd1, 5'd31, 5'd31, FN_SLL));
    wait_drained();

    // random part: bursts of mixed instructions, weighted toward the ones
    // that build up register and memory contents
    while (sent_count < 24 + RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 15)      word = r_type(5'($urandom), 5'($urandom), 5'($urandom),
                                          5'($urandom), FN_ADD);
        else if (pick < 27) word = r_type(5'($urandom), 5'($urandom), 5'($urandom),
                                          5'($urandom), FN_SUB);
        else if (pick < 37) word = r_type(5'($urandom), 5'($urandom), 5'($urandom),
                                          5'($urandom), FN_SLL);
        else if (pick < 47) word = r_type(5'($urandom), 5'($urandom), 5'($urandom),
                                          5'($urandom), FN_SRL);
        else if (pick < 51) word = r_type(5'($urandom), 5'($urandom), 5'($urandom),
                                          5'($urandom), FN_JR);
        else if (pick < 66) word = mem_access(OP_LW);
        else if (pick < 81) word = mem_access(OP_SW);
        else if (pick < 85) word = j_type(OP_J, 26'($urandom));
        else if (pick < 90) word = j_type(OP_JAL, 26'($urandom));
        else if (pick < 95) word = {OP_SPECIAL, 26'($urandom)};      // any funct
        else                word = $urandom;                         // raw noise
        send_word(word);
      end
      if (!drain_pause_done && sent_count >= DRAIN_PAUSE_AT) begin
        wait_drained();
        drain_pause_done = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        instruction_word <= $urandom;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end

    // drain, then give late or extra results time to show up
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
